// ===== rtl/core/four_op_register_machine_executor_top_assert.svh =====
// Assertion macros for the register machine executor.
// Each macro checks on the rising edge of clock and is quiet during reset.
`ifndef FOUR_OP_REGISTER_MACHINE_EXECUTOR_TOP_ASSERT_SVH
`define FOUR_OP_REGISTER_MACHINE_EXECUTOR_TOP_ASSERT_SVH

// Same-cycle implication
`define FRME_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define FRME_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/frme_pkg.sv =====
package frme_pkg;

   // Opcode byte values
   localparam logic [7:0] OP_ADD   = 8'h00;
   localparam logic [7:0] OP_LOAD  = 8'h01;
   localparam logic [7:0] OP_STORE = 8'h02;
   localparam logic [7:0] OP_MUL   = 8'h03;

   // Request command values
   localparam logic CMD_EXEC    = 1'b0;
   localparam logic CMD_PRELOAD = 1'b1;

   // Result outcome codes
   typedef enum logic [2:0] {
      OUT_ADD     = 3'd0,
      OUT_LOAD    = 3'd1,
      OUT_STORE   = 3'd2,
      OUT_MUL     = 3'd3,
      OUT_ILLEGAL = 3'd4,
      OUT_RANGE   = 3'd5,
      OUT_PRELOAD = 3'd6
   } outcome_type;

endpackage

// ===== rtl/core/frme_if.sv =====
// Request channel: one instruction or one preload
interface frme_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] instruction;
   logic [2:0]  preload_address;
   logic [31:0] preload_value;

   modport source (output valid, cmd, instruction, preload_address, preload_value,
                   input ready);
   modport sink   (input valid, cmd, instruction, preload_address, preload_value,
                   output ready);
endinterface

// Response channel: one result per request
interface frme_rsp_if;
   logic                      valid;
   logic                      ready;
   frme_pkg::outcome_type     outcome;
   logic [31:0]               value;

   modport source (output valid, outcome, value, input ready);
   modport sink   (input valid, outcome, value, output ready);
endinterface

// ===== rtl/core/four_op_register_machine_executor_top.sv =====
// Channel | Role   | Payload                                         | Handshake
// req_if  | sink   | cmd, instruction, preload_address, preload_value | valid/ready
// rsp_if  | source | outcome, value                                  | valid/ready
//
// One request per cycle when no response stall or clearing sweep holds req_if.ready low;
// each request is registered in stage 1, then its result in the response register.
// Stage 1 registers the request and the register file / data memory read data;
// stage 2 holds the response. A one-deep write bypass covers back-to-back hazards.
// After reset a clearing sweep zeroes both stores,
// and req_if.ready stays low during it.
// A stalled response holds stage 1; a new request enters as stage 1 drains.
`include "four_op_register_machine_executor_top_assert.svh"

module four_op_register_machine_executor_top #(
   parameter int NUM_REGS  = 8,
   parameter int MEM_WORDS = 8
) (
   input logic        clock,
   input logic        reset,
   frme_req_if.sink   req_if,
   frme_rsp_if.source rsp_if
);

   localparam int RIDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int MADDR_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int CLR_LEN = (NUM_REGS > MEM_WORDS) ? NUM_REGS : MEM_WORDS;
   localparam int CLR_W   = $clog2(CLR_LEN + 1);

   // Storage
   logic [31:0] rf_mem [NUM_REGS];
   logic [31:0] dm_mem [MEM_WORDS];

   // Clearing sweep
   logic [CLR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic             clr_busy;

   // Stage 1 request and read data
   logic              s1_v_ff, s1_v_in;
   logic              s1_cmd_ff;
   logic [31:0]       s1_instr_ff;
   logic [2:0]        s1_paddr_ff;
   logic [31:0]       s1_pval_ff;
   logic [31:0]       rd_a_ff, rd_b_ff, rd_m_ff;

   // Write bypass captured at the read edge
   logic              fwd_rf_v_ff, fwd_rf_v_in;
   logic [RIDX_W-1:0] fwd_rf_idx_ff;
   logic              fwd_dm_v_ff, fwd_dm_v_in;
   logic [MADDR_W-1:0] fwd_dm_idx_ff;
   logic [31:0]       fwd_data_ff;

   // Response register
   logic                  out_v_ff, out_v_in;
   frme_pkg::outcome_type out_outcome_ff, out_outcome_in;
   logic [31:0]           out_value_ff, out_value_in;

   // Handshake
   logic req_fire, adv;

   // Stage 1 decode
   logic [7:0]          op, r_hi, r_mid, r_lo;
   logic [15:0]         addr;
   logic                hi_ok, mid_ok, lo_ok, addr_ok, pre_ok;
   logic [RIDX_W-1:0]   hi_idx, mid_idx, lo_idx;
   logic [MADDR_W-1:0]  addr_idx;
   logic [31:0]         opa, opb, opm;
   logic                rf_we, dm_we;
   logic [RIDX_W-1:0]   rf_widx;
   logic [MADDR_W-1:0]  dm_widx;
   logic [31:0]         wdata;

   // Read addresses taken straight from the incoming request
   logic [RIDX_W-1:0]   rd_a_idx, rd_b_idx;
   logic [MADDR_W-1:0]  rd_m_idx;

   assign clr_busy = (clr_cnt_ff < CLR_W'(CLR_LEN));
   assign clr_cnt_in = clr_busy ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   // Advance stage 1 when the response register is free or drains
   assign adv      = s1_v_ff && (!out_v_ff || rsp_if.ready);
   assign req_if.ready = !clr_busy && (!s1_v_ff || adv);
   assign req_fire = req_if.valid && req_if.ready;

   assign rd_a_idx = req_if.instruction[16 +: RIDX_W];
   assign rd_b_idx = req_if.instruction[8 +: RIDX_W];
   assign rd_m_idx = req_if.instruction[MADDR_W-1:0];

   // Decode the held request
   always_comb begin
      op      = s1_instr_ff[31:24];
      r_hi    = s1_instr_ff[23:16];
      r_mid   = s1_instr_ff[15:8];
      r_lo    = s1_instr_ff[7:0];
      addr    = s1_instr_ff[15:0];
      hi_ok   = ({1'b0, r_hi}  < 9'(NUM_REGS));
      mid_ok  = ({1'b0, r_mid} < 9'(NUM_REGS));
      lo_ok   = ({1'b0, r_lo}  < 9'(NUM_REGS));
      addr_ok = ({1'b0, addr}  < 17'(MEM_WORDS));
      pre_ok  = (17'(s1_paddr_ff) < 17'(MEM_WORDS));
      hi_idx   = r_hi[RIDX_W-1:0];
      mid_idx  = r_mid[RIDX_W-1:0];
      lo_idx   = r_lo[RIDX_W-1:0];
      addr_idx = addr[MADDR_W-1:0];
   end

   // Bypass the write that landed on the same edge as the reads
   always_comb begin
      opa = (fwd_rf_v_ff && fwd_rf_idx_ff == hi_idx)  ? fwd_data_ff : rd_a_ff;
      opb = (fwd_rf_v_ff && fwd_rf_idx_ff == mid_idx) ? fwd_data_ff : rd_b_ff;
      opm = (fwd_dm_v_ff && fwd_dm_idx_ff == addr_idx) ? fwd_data_ff : rd_m_ff;
   end

   // Execute: result, outcome and store writes
   always_comb begin
      out_outcome_in = frme_pkg::OUT_RANGE;
      wdata          = '0;
      rf_we          = 1'b0;
      dm_we          = 1'b0;
      rf_widx        = lo_idx;
      dm_widx        = addr_idx;
      if (s1_cmd_ff == frme_pkg::CMD_PRELOAD) begin
         dm_widx = MADDR_W'(s1_paddr_ff);
         if (pre_ok) begin
            out_outcome_in = frme_pkg::OUT_PRELOAD;
            wdata          = s1_pval_ff;
            dm_we          = 1'b1;
         end
      end else begin
         case (op)
            frme_pkg::OP_ADD, frme_pkg::OP_MUL: begin
               if (hi_ok && mid_ok && lo_ok) begin
                  if (op == frme_pkg::OP_ADD) begin
                     out_outcome_in = frme_pkg::OUT_ADD;
                     wdata          = opa + opb;
                  end else begin
                     out_outcome_in = frme_pkg::OUT_MUL;
                     wdata          = opa * opb;
                  end
                  rf_we   = 1'b1;
                  rf_widx = lo_idx;
               end
            end
            frme_pkg::OP_LOAD: begin
               if (hi_ok && addr_ok) begin
                  out_outcome_in = frme_pkg::OUT_LOAD;
                  wdata          = opm;
                  rf_we          = 1'b1;
                  rf_widx        = hi_idx;
               end
            end
            frme_pkg::OP_STORE: begin
               if (hi_ok && addr_ok) begin
                  out_outcome_in = frme_pkg::OUT_STORE;
                  wdata          = opa;
                  dm_we          = 1'b1;
               end
            end
            default: begin
               out_outcome_in = frme_pkg::OUT_ILLEGAL;
            end
         endcase
      end
      out_value_in = wdata;
   end

   // Next control state
   always_comb begin
      s1_v_in     = req_fire || (s1_v_ff && !adv);
      out_v_in    = adv || (out_v_ff && !rsp_if.ready);
      fwd_rf_v_in = adv && rf_we;
      fwd_dm_v_in = adv && dm_we;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         s1_v_ff     <= 1'b0;
         out_v_ff    <= 1'b0;
         fwd_rf_v_ff <= 1'b0;
         fwd_dm_v_ff <= 1'b0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         s1_v_ff    <= s1_v_in;
         out_v_ff   <= out_v_in;
         if (req_fire) begin
            fwd_rf_v_ff <= fwd_rf_v_in;
            fwd_dm_v_ff <= fwd_dm_v_in;
         end
      end
   end

   // Stage 1 payload, read data and bypass data
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff     <= req_if.cmd;
         s1_instr_ff   <= req_if.instruction;
         s1_paddr_ff   <= req_if.preload_address;
         s1_pval_ff    <= req_if.preload_value;
         rd_a_ff       <= rf_mem[rd_a_idx];
         rd_b_ff       <= rf_mem[rd_b_idx];
         rd_m_ff       <= dm_mem[rd_m_idx];
         fwd_rf_idx_ff <= rf_widx;
         fwd_dm_idx_ff <= dm_widx;
         fwd_data_ff   <= wdata;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (adv) begin
         out_outcome_ff <= out_outcome_in;
         out_value_ff   <= out_value_in;
      end
   end

   // Register file write: clearing sweep, then executed requests
   always_ff @(posedge clock) begin
      if (clr_busy) begin
         if (clr_cnt_ff < CLR_W'(NUM_REGS)) begin
            rf_mem[clr_cnt_ff[RIDX_W-1:0]] <= '0;
         end
      end else if (adv && rf_we) begin
         rf_mem[rf_widx] <= wdata;
      end
   end

   // Data memory write: clearing sweep, then executed requests
   always_ff @(posedge clock) begin
      if (clr_busy) begin
         if (clr_cnt_ff < CLR_W'(MEM_WORDS)) begin
            dm_mem[clr_cnt_ff[MADDR_W-1:0]] <= '0;
         end
      end else if (adv && dm_we) begin
         dm_mem[dm_widx] <= wdata;
      end
   end

   assign rsp_if.valid   = out_v_ff;
   assign rsp_if.outcome = out_outcome_ff;
   assign rsp_if.value   = out_value_ff;

   // Checks
   `FRME_ASSERT_NOW(a_no_accept_in_clear, clr_busy, !req_fire,
      "request accepted during clearing sweep")
   `FRME_ASSERT_NEXT(a_accept_fills_s1, req_fire, s1_v_ff,
      "accepted request missing from stage 1")
   `FRME_ASSERT_NEXT(a_adv_fills_out, adv, out_v_ff,
      "advanced request missing from response register")
   `FRME_ASSERT_NOW(a_error_zero,
      out_v_ff && (out_outcome_ff == frme_pkg::OUT_ILLEGAL ||
                   out_outcome_ff == frme_pkg::OUT_RANGE),
      out_value_ff == 32'd0,
      "error response with nonzero value")
   `FRME_ASSERT_NOW(a_single_store_write, adv, !(rf_we && dm_we),
      "request writes both stores")

endmodule

// ===== verif/frme_execution_checker.sv =====
`timescale 1ns / 1ps

module frme_execution_checker #(
   parameter int NUM_REGS  = 8,
   parameter int MEM_WORDS = 8
) (
   input  logic clock,
   input  logic reset,
   frme_req_if  req_mon,
   frme_rsp_if  rsp_mon,
   output int   mismatches,
   output int   outstanding
);

   localparam int RIDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int MADDR_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

   typedef struct {
      frme_pkg::outcome_type outcome;
      logic [31:0]           value;
   } exec_result_type;

   // Shadow copy of the register file and the data memory
   logic [31:0] shadow_regs [NUM_REGS];
   logic [31:0] shadow_mem  [MEM_WORDS];

   // Results still owed by the block, oldest first
   exec_result_type owed_results [$];

   // Execute one request on the shadow state and return its result
   function automatic exec_result_type execute_request(input logic        cmd,
                                                       input logic [31:0] instr,
                                                       input logic [2:0]  pre_addr,
                                                       input logic [31:0] pre_value);
      exec_result_type    res;
      logic [7:0]         opcode;
      logic [7:0]         src_a;
      logic [7:0]         src_b;
      logic [7:0]         dst;
      logic [15:0]        mem_addr;
      logic [31:0]        sum;
      logic [RIDX_W-1:0]  a_idx;
      logic [RIDX_W-1:0]  b_idx;
      logic [RIDX_W-1:0]  d_idx;
      logic [MADDR_W-1:0] m_idx;
      logic [MADDR_W-1:0] p_idx;
      res.outcome = frme_pkg::OUT_RANGE;
      res.value   = '0;
      opcode   = instr[31:24];
      src_a    = instr[23:16];
      src_b    = instr[15:8];
      dst      = instr[7:0];
      mem_addr = instr[15:0];
      a_idx    = src_a[RIDX_W-1:0];
      b_idx    = src_b[RIDX_W-1:0];
      d_idx    = dst[RIDX_W-1:0];
      m_idx    = mem_addr[MADDR_W-1:0];
      p_idx    = MADDR_W'(pre_addr);
      if (cmd == frme_pkg::CMD_PRELOAD) begin
         if (int'(pre_addr) < MEM_WORDS) begin
            shadow_mem[p_idx] = pre_value;
            res.outcome = frme_pkg::OUT_PRELOAD;
            res.value   = pre_value;
         end
         return res;
      end
      case (opcode)
         frme_pkg::OP_ADD, frme_pkg::OP_MUL: begin
            // read both sources before the write so dst may alias either
            if (int'(src_a) < NUM_REGS && int'(src_b) < NUM_REGS &&
                int'(dst) < NUM_REGS) begin
               if (opcode == frme_pkg::OP_ADD) begin
                  sum = shadow_regs[a_idx] + shadow_regs[b_idx];
                  res.outcome = frme_pkg::OUT_ADD;
               end else begin
                  sum = shadow_regs[a_idx] * shadow_regs[b_idx];
                  res.outcome = frme_pkg::OUT_MUL;
               end
               shadow_regs[d_idx] = sum;
               res.value = sum;
            end
         end
         frme_pkg::OP_LOAD: begin
            if (int'(src_a) < NUM_REGS && int'(mem_addr) < MEM_WORDS) begin
               shadow_regs[a_idx] = shadow_mem[m_idx];
               res.outcome = frme_pkg::OUT_LOAD;
               res.value   = shadow_mem[m_idx];
            end
         end
         frme_pkg::OP_STORE: begin
            if (int'(src_a) < NUM_REGS && int'(mem_addr) < MEM_WORDS) begin
               shadow_mem[m_idx] = shadow_regs[a_idx];
               res.outcome = frme_pkg::OUT_STORE;
               res.value   = shadow_regs[a_idx];
            end
         end
         default: begin
            res.outcome = frme_pkg::OUT_ILLEGAL;
         end
      endcase
      return res;
   endfunction

   // Predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      exec_result_type want;
      int              bad;
      bad = 0;
      if (reset) begin
         foreach (shadow_regs[i]) shadow_regs[i] = '0;
         foreach (shadow_mem[i]) shadow_mem[i] = '0;
         owed_results.delete();
         mismatches  <= 0;
         outstanding <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            owed_results.push_back(execute_request(req_mon.cmd, req_mon.instruction,
                                                   req_mon.preload_address,
                                                   req_mon.preload_value));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_results.size() == 0) begin
               $error("unexpected response: outcome %0d value %h",
                      rsp_mon.outcome, rsp_mon.value);
               bad++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_mon.outcome !== want.outcome) begin
                  $error("outcome mismatch: expected %0d, actual %0d",
                         want.outcome, rsp_mon.outcome);
                  bad++;
               end
               if (rsp_mon.value !== want.value) begin
                  $error("value mismatch: expected %h, actual %h",
                         want.value, rsp_mon.value);
                  bad++;
               end
            end
         end
         mismatches  <= mismatches + bad;
         outstanding <= owed_results.size();
      end
   end

endmodule

// ===== verif/four_op_register_machine_executor_top_tb.sv =====
`timescale 1ns / 1ps

module four_op_register_machine_executor_top_tb;

   localparam int NUM_REGS        = 8;
   localparam int MEM_WORDS       = 8;
   localparam int RANDOM_ITEMS    = 680;
   localparam int STEADY_ITEMS    = 80;
   localparam int BACKLOG_ITEMS   = 30;
   localparam int RSP_HOLD_CYCLES = 80;

   logic clock = 1'b0;
   logic reset;
   logic hold_responses;
   logic steady_phase;
   bit   sender_idles;
   int   mismatches;
   int   outstanding;

   frme_req_if req_if ();
   frme_rsp_if rsp_if ();

   four_op_register_machine_executor_top #(
      .NUM_REGS (NUM_REGS),
      .MEM_WORDS(MEM_WORDS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   frme_execution_checker #(
      .NUM_REGS (NUM_REGS),
      .MEM_WORDS(MEM_WORDS)
   ) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Drive one request until accepted, then maybe drop valid for a burst
   task automatic offer(input logic cmd, input logic [31:0] instr,
                        input logic [2:0] pre_addr, input logic [31:0] pre_value);
      req_if.valid           <= 1'b1;
      req_if.cmd             <= cmd;
      req_if.instruction     <= instr;
      req_if.preload_address <= pre_addr;
      req_if.preload_value   <= pre_value;
      do @(posedge clock); while (!req_if.ready);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Drop valid and hold until every owed result has come back
   task automatic wait_all_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Request side: reset, directed requests, random requests, verdict
   initial begin
      int          k;
      int          pick;
      logic        cmd;
      logic [31:0] instr;
      logic [2:0]  pre_addr;
      logic [31:0] pre_value;
      logic [7:0]  opcode;
      logic [7:0]  mem_op;
      logic [7:0]  ra, rb, rd, bad_reg;
      logic [15:0] addr, bad_addr;
      reset                  <= 1'b1;
      req_if.valid           <= 1'b0;
      req_if.cmd             <= frme_pkg::CMD_EXEC;
      req_if.instruction     <= '0;
      req_if.preload_address <= '0;
      req_if.preload_value   <= '0;
      hold_responses         <= 1'b0;
      steady_phase           <= 1'b0;
      sender_idles = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: preloads, each opcode, wraparound, aliasing, bad indexes
      offer(frme_pkg::CMD_PRELOAD, $urandom(), 3'd0, 32'hFFFF_FFFF);
      offer(frme_pkg::CMD_PRELOAD, $urandom(), 3'd7, 32'h8000_0001);
      offer(frme_pkg::CMD_PRELOAD, 32'hFFFF_FFFF, 3'd3, 32'h0000_0000);
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_LOAD, 8'd0, 16'd0}, 3'd7, $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_LOAD, 8'd7, 16'd7}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_ADD, 8'd0, 8'd7, 8'd1}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_MUL, 8'd0, 8'd7, 8'd0}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_ADD, 8'd1, 8'd1, 8'd1}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_STORE, 8'd1, 16'd7}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_STORE, 8'd7, 16'd0}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_LOAD, 8'd2, 16'd7}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_MUL, 8'd2, 8'd2, 8'd6}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {8'd4, 24'h000102}, 3'($urandom()), $urandom());
      offer(frme_pkg::CMD_EXEC, {8'hFF, 24'hFFFFFF}, 3'($urandom()), $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_ADD, 8'd8, 8'd0, 8'd1}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_MUL, 8'd1, 8'hFF, 8'd2}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_ADD, 8'd1, 8'd2, 8'd8}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_LOAD, 8'd8, 16'd0}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_LOAD, 8'd0, 16'd8}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_STORE, 8'd0, 16'hFFFF}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_STORE, 8'hFF, 16'd7}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_LOAD, 8'd3, 16'h0100}, 3'($urandom()),
            $urandom());
      offer(frme_pkg::CMD_PRELOAD, 32'hFFFF_FFFF, 3'd5, 32'hA5A5_5A5A);
      offer(frme_pkg::CMD_EXEC, {frme_pkg::OP_ADD, 8'd5, 8'd5, 8'd5}, 3'd7, 32'hFFFF_FFFF);

      // Random: mostly legal programs, some bad indexes, opcodes and noise
      hold_responses <= 1'b1;
      sender_idles = 1'b0;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == BACKLOG_ITEMS) sender_idles = 1'b1;
         if (k == RANDOM_ITEMS / 2) wait_all_results();
         if (k == RANDOM_ITEMS - STEADY_ITEMS) begin
            sender_idles = 1'b0;
            steady_phase <= 1'b1;
         end
         pick      = $urandom_range(0, 99);
         cmd       = frme_pkg::CMD_EXEC;
         instr     = $urandom();
         pre_addr  = 3'($urandom_range(0, 7));
         pre_value = $urandom();
         opcode    = $urandom_range(0, 1) ? frme_pkg::OP_MUL : frme_pkg::OP_ADD;
         mem_op    = $urandom_range(0, 1) ? frme_pkg::OP_LOAD : frme_pkg::OP_STORE;
         ra        = 8'($urandom_range(0, NUM_REGS - 1));
         rb        = 8'($urandom_range(0, NUM_REGS - 1));
         rd        = 8'($urandom_range(0, NUM_REGS - 1));
         addr      = 16'($urandom_range(0, MEM_WORDS - 1));
         bad_reg   = 8'($urandom_range(NUM_REGS, 255));
         bad_addr  = 16'($urandom_range(MEM_WORDS, 16'hFFFF));
         if (pick < 15) begin
            cmd = frme_pkg::CMD_PRELOAD;
            if ($urandom_range(0, 7) == 0) pre_value = $urandom_range(0, 1) ? '1 : '0;
         end else if (pick < 82) begin
            case ($urandom_range(0, 3))
               0: instr = {opcode, ra, rb, rd};
               1: instr = {frme_pkg::OP_LOAD, ra, addr};
               2: instr = {frme_pkg::OP_STORE, ra, addr};
               default: instr = {opcode, ra, rb, rd};
            endcase
         end else if (pick < 90) begin
            case ($urandom_range(0, 4))
               0: instr = {opcode, bad_reg, rb, rd};
               1: instr = {opcode, ra, bad_reg, rd};
               2: instr = {opcode, ra, rb, bad_reg};
               3: instr = {mem_op, bad_reg, addr};
               default: instr = {mem_op, ra, bad_addr};
            endcase
         end else if (pick < 96) begin
            instr[31:24] = 8'($urandom_range(4, 255));
         end
         offer(cmd, instr, pre_addr, pre_value);
      end

      // Drain, let the pipeline settle, then give the verdict
      wait_all_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("four_op_register_machine_executor_top verification clean");
      end else begin
         $display("four_op_register_machine_executor_top verification failed");
      end
      $finish;
   end

   // Response side: random stalls, one long hold-off to back up the pipe, then ready held high
   initial begin
      bit held;
      held = 1'b0;
      rsp_if.ready <= 1'b1;
      @(posedge clock);
      while (!steady_phase) begin
         if (hold_responses && !held) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end else begin
            @(posedge clock);
         end
      end
      rsp_if.ready <= 1'b1;
   end

   // Hard stop if the run hangs
   initial begin
      #400000;
      $display("four_op_register_machine_executor_top verification failed");
      $finish;
   end

endmodule
